[design/gbr_pkg.sv]
// Package for the gamma bitstream reader.
// Holds field widths, command and state codes, and the controller/datapath structs.
// No dependencies.
package gbr_pkg;

  localparam int LEN_W           = 13;   // stream length and byte cursor
  localparam int ADDR_IN_W       = 12;   // load address field
  localparam int BYTE_W          = 8;
  localparam int CNT_W           = 4;
  localparam int VAL_W           = 16;
  localparam int POS_W           = 3;
  localparam int LEFT_W          = 16;   // holds any zero-run length of a full stream
  localparam int STORE_DEPTH_DEF = 4096;

  localparam logic [CNT_W-1:0] MAX_BITS = CNT_W'(8);

  typedef enum logic [2:0] {
    CMD_LOAD    = 3'd0,
    CMD_RESTART = 3'd1,
    CMD_BIT     = 3'd2,
    CMD_FIXED   = 3'd3,
    CMD_ALIGNED = 3'd4,
    CMD_GAMMA   = 3'd5,
    CMD_HYBRID  = 3'd6
  } gbr_cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_BIT,
    ST_FETCH,
    ST_ALIGN,
    ST_OUT
  } gbr_state_t;

  typedef enum logic [1:0] {
    PH_ZEROS,
    PH_TAIL,
    PH_FIXED
  } gbr_phase_t;

  typedef struct packed {
    logic latch;
    logic load_wr;
    logic restart;
    logic acc_clear;
    logic acc_one;
    logic acc_shift;
    logic left_load_count;
    logic left_clear;
    logic left_inc;
    logic left_dec;
    logic ram_rd;
    logic fetch_take;
    logic bit_adv;
    logic align_take;
    logic g_save;
    logic set_fault;
    logic out_load;
  } gbr_ctl_t;

  typedef struct packed {
    gbr_cmd_t cmd;
    logic     count_zero;
    logic     pos_zero;
    logic     at_end;
    logic     bit_held;
    logic     bit_fetch;
    logic     left_one;
    logic     left_zero;
    logic     out_free;
  } gbr_sts_t;

endpackage

[design/gbr_ifs.sv]
// Channel interfaces of the gamma bitstream reader: requests (loads and reads), results and
// the stream length write channel. Depends on gbr_pkg for widths.
interface gbr_in_if;
  logic                            valid;
  logic                            ready;
  logic [2:0]                      command;
  logic [gbr_pkg::ADDR_IN_W-1:0]   load_address;
  logic [gbr_pkg::BYTE_W-1:0]      load_byte;
  logic [gbr_pkg::CNT_W-1:0]       bit_count;

  modport source (output valid, command, load_address, load_byte, bit_count, input ready);
  modport sink (input valid, command, load_address, load_byte, bit_count, output ready);
endinterface

interface gbr_out_if;
  logic                        valid;
  logic                        ready;
  logic [gbr_pkg::VAL_W-1:0]   value;
  logic                        past_end;

  modport source (output valid, value, past_end, input ready);
  modport sink (input valid, value, past_end, output ready);
endinterface

interface gbr_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [gbr_pkg::LEN_W-1:0]   stream_length;

  modport source (output valid, stream_length, input ready);
  modport sink (input valid, stream_length, output ready);
endinterface

[design/gamma_bitstream_reader_top.sv]
// Top level of the gamma bitstream reader: joins the controller and datapath
// to the channel interfaces. Depends on gbr_pkg, gbr_ifs, gbr_ctrl, gbr_dpath.
//
//   Channel    Direction  Payload                                      Transaction
//   in_chan    in         command, load_address, load_byte, bit_count  valid & ready
//   out_chan   out        value, past_end (one per request)            valid & ready
//   cfg_chan   in         stream_length                                valid & ready
//
// A request passes through an accept state, a decode state, a bit state for each
// stream bit consumed, a fetch state for each byte read through the store's
// registered read port, and an output state that loads the result register; an
// aligned byte takes its read in an align state. The result register lets the next
// request be accepted while a result waits; a stalled out_chan holds the block only
// at hand-off. Reset clears the cursor, bit position, held byte and stream length;
// the store is not cleared, and cfg_chan is always ready.
module gamma_bitstream_reader_top #(
  parameter int STORE_DEPTH = gbr_pkg::STORE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  gbr_in_if.sink     in_chan,
  gbr_out_if.source  out_chan,
  gbr_cfg_if.sink    cfg_chan
);

  import gbr_pkg::*;

  gbr_ctl_t ctl;
  gbr_sts_t sts;
  logic     in_ready;

  assign in_chan.ready  = in_ready;
  assign cfg_chan.ready = 1'b1;

  gbr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .ctl      (ctl)
  );

  gbr_dpath #(
    .STORE_DEPTH (STORE_DEPTH)
  ) u_dpath (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_command        (in_chan.command),
    .in_load_address   (in_chan.load_address),
    .in_load_byte      (in_chan.load_byte),
    .in_bit_count      (in_chan.bit_count),
    .cfg_valid         (cfg_chan.valid),
    .cfg_stream_length (cfg_chan.stream_length),
    .out_valid         (out_chan.valid),
    .out_ready         (out_chan.ready),
    .out_value         (out_chan.value),
    .out_past_end      (out_chan.past_end),
    .ctl               (ctl),
    .sts               (sts)
  );

endmodule

[design/gbr_ram.sv]
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies.
module gbr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                              clk,
  input  logic                              wr_en,
  input  logic [$clog2(DEPTH)-1:0]          wr_addr,
  input  logic [WIDTH-1:0]                  wr_data,
  input  logic                              rd_en,
  input  logic [$clog2(DEPTH)-1:0]          rd_addr,
  output logic [WIDTH-1:0]                  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[design/gbr_ctrl.sv]
// Controller of the gamma bitstream reader: sequences decode, bit steps,
// byte fetches and the result hand-off. Depends on gbr_pkg.
module gbr_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  gbr_pkg::gbr_sts_t sts,
  output gbr_pkg::gbr_ctl_t ctl
);

  import gbr_pkg::*;

  gbr_state_t state_r, state_nxt;
  gbr_phase_t phase_r, phase_nxt;
  logic       take;
  logic       take_bit;
  logic       gamma_done;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      phase_r <= PH_ZEROS;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    phase_nxt  = phase_r;
    ctl        = '0;
    in_ready   = 1'b0;
    take       = 1'b0;
    take_bit   = 1'b0;
    gamma_done = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctl.latch = 1'b1;
          state_nxt = ST_DECODE;
        end
      end
      ST_DECODE: begin
        unique case (sts.cmd) inside
          CMD_LOAD: begin
            ctl.load_wr = 1'b1;
            state_nxt   = ST_OUT;
          end
          CMD_RESTART: begin
            ctl.restart = 1'b1;
            state_nxt   = ST_OUT;
          end
          CMD_BIT, CMD_FIXED: begin
            ctl.acc_clear       = 1'b1;
            ctl.left_load_count = 1'b1;
            phase_nxt           = PH_FIXED;
            state_nxt           = sts.count_zero ? ST_OUT : ST_BIT;
          end
          CMD_ALIGNED: begin
            if (sts.at_end) begin
              ctl.set_fault = 1'b1;
              state_nxt     = ST_OUT;
            end else begin
              ctl.ram_rd = 1'b1;
              state_nxt  = ST_ALIGN;
            end
          end
          CMD_GAMMA, CMD_HYBRID: begin
            ctl.acc_one    = 1'b1;
            ctl.left_clear = 1'b1;
            phase_nxt      = PH_ZEROS;
            state_nxt      = ST_BIT;
          end
          default: state_nxt = ST_OUT;
        endcase
      end
      ST_BIT: begin
        if (sts.pos_zero) begin
          // The held byte is used up, so the next bit needs a fresh byte.
          if (sts.at_end) begin
            ctl.set_fault = 1'b1;
            state_nxt     = ST_OUT;
          end else begin
            ctl.ram_rd = 1'b1;
            state_nxt  = ST_FETCH;
          end
        end else begin
          take     = 1'b1;
          take_bit = sts.bit_held;
        end
      end
      ST_FETCH: begin
        ctl.fetch_take = 1'b1;
        take           = 1'b1;
        take_bit       = sts.bit_fetch;
        state_nxt      = ST_BIT;
      end
      ST_ALIGN: begin
        ctl.align_take = 1'b1;
        state_nxt      = ST_OUT;
      end
      ST_OUT: begin
        if (sts.out_free) begin
          ctl.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    if (take) begin
      ctl.bit_adv = 1'b1;
      unique case (phase_r)
        PH_FIXED: begin
          ctl.acc_shift = 1'b1;
          ctl.left_dec  = 1'b1;
          if (sts.left_one) begin
            state_nxt = ST_OUT;
          end
        end
        PH_ZEROS: begin
          if (!take_bit) begin
            ctl.left_inc = 1'b1;
          end else if (sts.left_zero) begin
            gamma_done = 1'b1;
          end else begin
            phase_nxt = PH_TAIL;
          end
        end
        PH_TAIL: begin
          ctl.acc_shift = 1'b1;
          ctl.left_dec  = 1'b1;
          if (sts.left_one) begin
            gamma_done = 1'b1;
          end
        end
        default: state_nxt = ST_OUT;
      endcase

      if (gamma_done) begin
        if (sts.cmd == CMD_HYBRID) begin
          // Keep gamma-1 and go on with the fixed low bits.
          ctl.g_save          = 1'b1;
          ctl.left_load_count = 1'b1;
          phase_nxt           = PH_FIXED;
          if (sts.count_zero) begin
            state_nxt = ST_OUT;
          end
        end else begin
          state_nxt = ST_OUT;
        end
      end
    end
  end

  a_fetch_after_bit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FETCH) |-> $past(state_r == ST_BIT && sts.pos_zero))
    else $error("fetch state entered without an empty held byte");

  a_decode_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DECODE) |-> $past(in_valid && in_ready))
    else $error("decode without an accepted transaction");

endmodule

[design/gbr_dpath.sv]
// Datapath of the gamma bitstream reader: stream store, cursor, held byte,
// bit counters, value assembly and the result register. Depends on gbr_pkg, gbr_ram.
module gbr_dpath #(
  parameter int STORE_DEPTH = gbr_pkg::STORE_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic [2:0]                      in_command,
  input  logic [gbr_pkg::ADDR_IN_W-1:0]   in_load_address,
  input  logic [gbr_pkg::BYTE_W-1:0]      in_load_byte,
  input  logic [gbr_pkg::CNT_W-1:0]       in_bit_count,
  input  logic                            cfg_valid,
  input  logic [gbr_pkg::LEN_W-1:0]       cfg_stream_length,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [gbr_pkg::VAL_W-1:0]       out_value,
  output logic                            out_past_end,
  input  gbr_pkg::gbr_ctl_t               ctl,
  output gbr_pkg::gbr_sts_t               sts
);

  import gbr_pkg::*;

  localparam int RAM_AW = $clog2(STORE_DEPTH);

  gbr_cmd_t              cmd_r;
  logic [CNT_W-1:0]      cnt_r;
  logic [ADDR_IN_W-1:0]  ld_addr_r;
  logic [BYTE_W-1:0]     ld_byte_r;
  logic [LEN_W-1:0]      len_r;
  logic [LEN_W-1:0]      cursor_r;
  logic [POS_W-1:0]      bit_pos_r;
  logic [BYTE_W-1:0]     held_r;
  logic [LEFT_W-1:0]     left_r;
  logic [BYTE_W-1:0]     acc_r;
  logic [BYTE_W-1:0]     g_r;
  logic                  fault_r;
  logic                  out_valid_r;
  logic [VAL_W-1:0]      value_r;
  logic                  past_end_r;

  logic [BYTE_W-1:0]     rd_data;
  logic [RAM_AW-1:0]     rd_addr;
  logic [RAM_AW-1:0]     wr_addr;
  logic                  ld_in_range;
  logic                  at_end;
  logic                  cur_bit;
  logic [BYTE_W-1:0]     acc_step;
  logic [CNT_W-1:0]      cnt_in;
  logic [VAL_W-1:0]      result;

  assign rd_addr     = RAM_AW'(cursor_r);
  assign wr_addr     = RAM_AW'(ld_addr_r);
  assign ld_in_range = (32'(ld_addr_r) < 32'(STORE_DEPTH));
  // The cursor is past the end when it reaches the length or the store size.
  assign at_end      = (cursor_r >= len_r) || (32'(cursor_r) >= 32'(STORE_DEPTH));
  assign cur_bit     = ctl.fetch_take ? rd_data[0] : held_r[bit_pos_r];
  assign acc_step    = ctl.acc_shift ? {acc_r[BYTE_W-2:0], cur_bit} : acc_r;
  assign cnt_in      = (in_bit_count > MAX_BITS) ? MAX_BITS : in_bit_count;

  gbr_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (ctl.load_wr && ld_in_range),
    .wr_addr (wr_addr),
    .wr_data (ld_byte_r),
    .rd_en   (ctl.ram_rd),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r     <= '0;
      cursor_r  <= '0;
      bit_pos_r <= '0;
      held_r    <= '0;
      fault_r   <= 1'b0;
    end else begin
      if (cfg_valid) begin
        len_r <= cfg_stream_length;
      end
      if (ctl.restart) begin
        cursor_r  <= '0;
        bit_pos_r <= '0;
        held_r    <= '0;
      end else begin
        if (ctl.fetch_take) begin
          held_r <= rd_data;
        end
        if (ctl.fetch_take || ctl.align_take) begin
          cursor_r <= cursor_r + LEN_W'(1);
        end
        if (ctl.bit_adv) begin
          bit_pos_r <= bit_pos_r + POS_W'(1);
        end
      end
      if (ctl.latch) begin
        fault_r <= 1'b0;
      end else if (ctl.set_fault) begin
        fault_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.latch) begin
      cmd_r     <= gbr_cmd_t'(in_command);
      cnt_r     <= (gbr_cmd_t'(in_command) == CMD_BIT) ? CNT_W'(1) : cnt_in;
      ld_addr_r <= in_load_address;
      ld_byte_r <= in_load_byte;
    end

    if (ctl.left_load_count) begin
      left_r <= LEFT_W'(cnt_r);
    end else if (ctl.left_clear) begin
      left_r <= '0;
    end else if (ctl.left_inc) begin
      left_r <= left_r + LEFT_W'(1);
    end else if (ctl.left_dec) begin
      left_r <= left_r - LEFT_W'(1);
    end

    if (ctl.g_save) begin
      g_r   <= acc_step - BYTE_W'(1);
      acc_r <= '0;
    end else if (ctl.acc_clear) begin
      acc_r <= '0;
    end else if (ctl.acc_one) begin
      acc_r <= BYTE_W'(1);
    end else if (ctl.align_take) begin
      acc_r <= rd_data;
    end else begin
      acc_r <= acc_step;
    end
  end

  always_comb begin
    case (cmd_r) inside
      CMD_BIT, CMD_FIXED, CMD_ALIGNED, CMD_GAMMA: result = VAL_W'(acc_r);
      CMD_HYBRID: result = (VAL_W'(g_r) << cnt_r) | VAL_W'(acc_r);
      default:    result = '0;
    endcase
  end

  // Result register: the next transaction can be taken while this one waits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      value_r    <= fault_r ? '0 : result;
      past_end_r <= fault_r;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_value    = value_r;
  assign out_past_end = past_end_r;

  always_comb begin
    sts            = '0;
    sts.cmd        = cmd_r;
    sts.count_zero = (cnt_r == '0);
    sts.pos_zero   = (bit_pos_r == '0);
    sts.at_end     = at_end;
    sts.bit_held   = held_r[bit_pos_r];
    sts.bit_fetch  = rd_data[0];
    sts.left_one   = (left_r == LEFT_W'(1));
    sts.left_zero  = (left_r == '0);
    sts.out_free   = !out_valid_r || out_ready;
  end

  a_read_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.ram_rd |-> !at_end)
    else $error("store read issued at or past the stream end");

  a_out_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.out_load |-> (!out_valid_r || out_ready))
    else $error("result register overwritten before it was taken");

  a_align_keeps_bits: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.align_take |=> ($stable(bit_pos_r) && $stable(held_r)))
    else $error("aligned byte read disturbed the bit position or held byte");

endmodule

[dv/gbr_tb_pkg.sv]
// Request/result types and the decode scoreboard for the gamma bitstream reader bench.
// The scoreboard mirrors the store, cursor, bit position and held byte of the block.
// Depends on gbr_pkg for widths and command codes.
package gbr_tb_pkg;
  import gbr_pkg::*;

  localparam logic [2:0] CMD_UNUSED = 3'd7;

  typedef struct packed {
    logic [2:0]           command;
    logic [ADDR_IN_W-1:0] load_address;
    logic [BYTE_W-1:0]    load_byte;
    logic [CNT_W-1:0]     bit_count;
  } stream_request_t;

  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic             past_end;
  } decode_result_t;

  class bit_reader_checker;
    logic [BYTE_W-1:0] store [STORE_DEPTH_DEF];
    bit                written [STORE_DEPTH_DEF];
    logic [LEN_W-1:0]  stream_length;
    logic [LEN_W-1:0]  cursor;
    logic [POS_W-1:0]  bit_pos;
    logic [BYTE_W-1:0] held;
    bit                fault;
    int                hole_addr;
    int                errors;
    decode_result_t    pending_decodes[$];

    function new();
      stream_length = '0;
      cursor = '0;
      bit_pos = '0;
      held = '0;
      fault = 1'b0;
      hole_addr = -1;
      errors = 0;
      foreach (written[i]) written[i] = 1'b0;
    endfunction

    // A fetch of a never-loaded entry is flagged and stops the read; the bench
    // only runs into that on a trial decode and loads the entry first.
    function bit fetch_byte(output logic [BYTE_W-1:0] data);
      int limit;
      limit = (stream_length > STORE_DEPTH_DEF) ? STORE_DEPTH_DEF : int'(stream_length);
      data = '0;
      if (int'(cursor) >= limit) begin
        fault = 1'b1;
        return 1'b0;
      end
      if (!written[cursor]) begin
        if (hole_addr < 0) hole_addr = int'(cursor);
        fault = 1'b1;
        return 1'b0;
      end
      data = store[cursor];
      cursor = cursor + 1'b1;
      return 1'b1;
    endfunction

    function logic take_bit();
      logic [BYTE_W-1:0] fresh;
      logic              b;
      if (fault) return 1'b0;
      if (bit_pos == 0) begin
        if (!fetch_byte(fresh)) return 1'b0;
        held = fresh;
      end
      b = held[bit_pos];
      bit_pos = bit_pos + 3'd1;
      return b;
    endfunction

    function logic [BYTE_W-1:0] take_bits(int n);
      logic [BYTE_W-1:0] v;
      v = '0;
      for (int i = 0; i < n && !fault; i++) v = {v[BYTE_W-2:0], take_bit()};
      return v;
    endfunction

    function logic [BYTE_W-1:0] take_gamma();
      logic [BYTE_W-1:0] v;
      logic              b;
      int                zeros;
      v = 8'd1;
      zeros = 0;
      forever begin
        b = take_bit();
        if (fault) return '0;
        if (b) break;
        zeros++;
      end
      for (int i = 0; i < zeros && !fault; i++) v = {v[BYTE_W-2:0], take_bit()};
      return v;
    endfunction

    function decode_result_t decode_request(stream_request_t req);
      decode_result_t    res;
      logic [VAL_W-1:0]  v;
      logic [BYTE_W-1:0] b8;
      logic [BYTE_W-1:0] gamma_part;
      int                cnt;
      cnt = (req.bit_count > MAX_BITS) ? int'(MAX_BITS) : int'(req.bit_count);
      fault = 1'b0;
      v = '0;
      case (req.command)
        CMD_LOAD: begin
          store[req.load_address] = req.load_byte;
          written[req.load_address] = 1'b1;
        end
        CMD_RESTART: begin
          cursor = '0;
          bit_pos = '0;
          held = '0;
        end
        CMD_BIT:     v = VAL_W'(take_bit());
        CMD_FIXED:   v = VAL_W'(take_bits(cnt));
        CMD_ALIGNED: if (fetch_byte(b8)) v = VAL_W'(b8);
        CMD_GAMMA:   v = VAL_W'(take_gamma());
        CMD_HYBRID: begin
          gamma_part = take_gamma() - 8'd1;
          if (!fault) begin
            v = VAL_W'(gamma_part) << cnt;
            v = v | VAL_W'(take_bits(cnt));
          end
        end
        default: ;
      endcase
      if (fault) v = '0;
      res.value = v;
      res.past_end = fault;
      return res;
    endfunction

    // Trial decode on the current state; returns the first never-loaded store
    // entry the request would fetch, or -1.
    function int first_unwritten(stream_request_t req);
      logic [LEN_W-1:0]  saved_cursor;
      logic [POS_W-1:0]  saved_pos;
      logic [BYTE_W-1:0] saved_held;
      decode_result_t    dummy;
      saved_cursor = cursor;
      saved_pos = bit_pos;
      saved_held = held;
      hole_addr = -1;
      dummy = decode_request(req);
      cursor = saved_cursor;
      bit_pos = saved_pos;
      held = saved_held;
      return hole_addr;
    endfunction

    function void record_request(stream_request_t req);
      pending_decodes.push_back(decode_request(req));
    endfunction

    function void check_decode(logic [VAL_W-1:0] value, logic past_end);
      decode_result_t exp;
      if (pending_decodes.size() == 0) begin
        $error("unexpected result transaction: value %0h past_end %0b", value, past_end);
        errors++;
        return;
      end
      exp = pending_decodes.pop_front();
      if (value !== exp.value) begin
        $error("value: expected %0h, actual %0h", exp.value, value);
        errors++;
      end
      if (past_end !== exp.past_end) begin
        $error("past_end: expected %0b, actual %0b", exp.past_end, past_end);
        errors++;
      end
    endfunction

    function int pending();
      return pending_decodes.size();
    endfunction
  endclass

endpackage

[dv/testbench.sv]
// Top of the gamma bitstream reader bench: clock, reset, request and length drivers,
// and the result sink that feeds the decode scoreboard.
// Depends on gbr_pkg, gbr_ifs, gbr_tb_pkg and gamma_bitstream_reader_top.
module testbench;
  import gbr_pkg::*;
  import gbr_tb_pkg::*;

  logic clk;
  logic rst_n;
  bit   in_burst;
  bit   out_burst;
  int   requests_sent;

  bit_reader_checker sb = new();

  gbr_in_if  in_chan ();
  gbr_out_if out_chan ();
  gbr_cfg_if cfg_chan ();

  gamma_bitstream_reader_top uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_chan (cfg_chan)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  initial begin
    #36000000;
    $display("testbench: FAIL");
    $finish;
  end

  function automatic int draw_gap(bit burst);
    return burst ? 0 : $urandom_range(0, 16);
  endfunction

  function automatic logic [BYTE_W-1:0] data_byte();
    case ($urandom_range(0, 9))
      0: return 8'h00;
      1: return 8'hFF;
      2: return 8'(1 << $urandom_range(0, 7));
      default: return 8'($urandom());
    endcase
  endfunction

  function automatic stream_request_t make_req(logic [2:0] cmd, int addr, int data, int cnt);
    stream_request_t req;
    req.command = cmd;
    req.load_address = ADDR_IN_W'(addr);
    req.load_byte = BYTE_W'(data);
    req.bit_count = CNT_W'(cnt);
    return req;
  endfunction

  function automatic bit reads_stream(logic [2:0] cmd);
    case (cmd)
      CMD_BIT, CMD_FIXED, CMD_ALIGNED, CMD_GAMMA, CMD_HYBRID: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic stream_request_t random_request();
    stream_request_t req;
    int              sel;
    req = make_req(CMD_UNUSED, $urandom_range(0, 4095), $urandom_range(0, 255),
                   ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 8));
    sel = $urandom_range(0, 99);
    if (sel < 8) begin
      req.command = CMD_LOAD;
      req.load_byte = data_byte();
      // Half of the loads land just ahead of the cursor, rewriting unread bytes.
      if ($urandom_range(0, 1)) req.load_address = ADDR_IN_W'(int'(sb.cursor) + $urandom_range(0, 7));
    end
    else if (sel < 12) req.command = CMD_RESTART;
    else if (sel < 14) req.command = CMD_UNUSED;
    else if (sel < 26) req.command = CMD_BIT;
    else if (sel < 44) req.command = CMD_FIXED;
    else if (sel < 56) req.command = CMD_ALIGNED;
    else if (sel < 78) req.command = CMD_GAMMA;
    else req.command = CMD_HYBRID;
    return req;
  endfunction

  function automatic int pick_length();
    case ($urandom_range(0, 9))
      0: return 0;
      1: return 1;
      2, 3, 4: return $urandom_range(2, 48);
      5, 6: return $urandom_range(49, 600);
      7: return $urandom_range(601, 4095);
      8: return STORE_DEPTH_DEF;
      default: return $urandom_range(0, 1) ? 8191 : $urandom_range(4097, 8191);
    endcase
  endfunction

  task automatic send_request(input stream_request_t req);
    int gap;
    gap = draw_gap(in_burst);
    if (gap > 0) begin
      @(negedge clk);
      in_chan.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_chan.command <= req.command;
    in_chan.load_address <= req.load_address;
    in_chan.load_byte <= req.load_byte;
    in_chan.bit_count <= req.bit_count;
    in_chan.valid <= 1'b1;
    do @(posedge clk); while (in_chan.ready !== 1'b1);
    sb.record_request(req);
    requests_sent++;
  endtask

  // Before a read, load every store entry it would fetch that was never written.
  task automatic issue(input stream_request_t req);
    int hole;
    if (reads_stream(req.command)) begin
      hole = sb.first_unwritten(req);
      while (hole >= 0) begin
        send_request(make_req(CMD_LOAD, hole, data_byte(), 0));
        hole = sb.first_unwritten(req);
      end
    end
    send_request(req);
  endtask

  task automatic drain();
    @(negedge clk);
    in_chan.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_length(input int len);
    drain();
    repeat (4) @(posedge clk);
    @(negedge clk);
    cfg_chan.stream_length <= LEN_W'(len);
    cfg_chan.valid <= 1'b1;
    do @(posedge clk); while (cfg_chan.ready !== 1'b1);
    sb.stream_length = LEN_W'(len);
    @(negedge clk);
    cfg_chan.valid <= 1'b0;
  endtask

  initial begin : result_sink
    int gap;
    wait (rst_n === 1'b1);
    forever begin
      gap = draw_gap(out_burst);
      repeat (gap) begin
        @(negedge clk);
        out_chan.ready <= 1'b0;
      end
      @(negedge clk);
      out_chan.ready <= 1'b1;
      do @(posedge clk); while (!(out_chan.valid === 1'b1 && out_chan.ready === 1'b1));
      sb.check_decode(out_chan.value, out_chan.past_end);
    end
  end

  initial begin : stimulus
    int len;
    int phase;
    rst_n = 1'b0;
    in_chan.valid = 1'b0;
    in_chan.command = '0;
    in_chan.load_address = '0;
    in_chan.load_byte = '0;
    in_chan.bit_count = '0;
    out_chan.ready = 1'b0;
    cfg_chan.valid = 1'b0;
    cfg_chan.stream_length = '0;
    requests_sent = 0;
    in_burst = 1'b0;
    out_burst = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Empty stream after reset: every fetch runs past the end.
    issue(make_req(CMD_BIT, 0, 0, 0));
    issue(make_req(CMD_ALIGNED, 0, 0, 0));
    issue(make_req(CMD_GAMMA, 0, 0, 0));
    issue(make_req(CMD_HYBRID, 0, 0, 8));
    issue(make_req(CMD_FIXED, 0, 0, 0));
    issue(make_req(CMD_UNUSED, 4095, 255, 15));
    issue(make_req(CMD_LOAD, 0, 8'h00, 0));
    issue(make_req(CMD_LOAD, 1, 8'h80, 0));
    issue(make_req(CMD_LOAD, 2, 8'hFF, 0));
    issue(make_req(CMD_LOAD, 3, 8'hFF, 0));
    issue(make_req(CMD_LOAD, 4095, 8'h5A, 15));

    // Fifteen zeros then seventeen ones: the gamma value wraps, then the stream ends mid-read.
    write_length(4);
    issue(make_req(CMD_GAMMA, 0, 0, 0));
    issue(make_req(CMD_BIT, 0, 0, 0));
    issue(make_req(CMD_BIT, 0, 0, 0));
    issue(make_req(CMD_RESTART, 0, 0, 0));
    issue(make_req(CMD_ALIGNED, 0, 0, 0));
    issue(make_req(CMD_FIXED, 0, 0, 15));
    issue(make_req(CMD_HYBRID, 0, 0, 3));
    issue(make_req(CMD_HYBRID, 0, 0, 8));
    issue(make_req(CMD_GAMMA, 0, 0, 0));

    // A gamma value of 256 wraps to zero, so the hybrid prefix becomes 255.
    write_length(8191);
    issue(make_req(CMD_LOAD, 1, 8'h01, 0));
    issue(make_req(CMD_LOAD, 2, 8'h00, 0));
    issue(make_req(CMD_RESTART, 0, 0, 0));
    issue(make_req(CMD_HYBRID, 0, 0, 2));
    issue(make_req(CMD_ALIGNED, 0, 0, 0));

    phase = 0;
    while (requests_sent < 1575) begin
      case (phase)
        0: len = 0;
        1: len = STORE_DEPTH_DEF;
        2: len = 8191;
        default: len = pick_length();
      endcase
      write_length(len);
      in_burst = ($urandom_range(0, 3) == 0);
      out_burst = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 1)) issue(make_req(CMD_RESTART, 0, 0, 0));
      repeat ($urandom_range(40, 120)) issue(random_request());
      phase++;
    end

    drain();
    repeat (40) @(posedge clk);
    if (sb.errors == 0)
      $display("testbench: PASS");
    else
      $display("testbench: FAIL");
    $finish;
  end

endmodule
